// ===== design/fmsp_pkg.sv =====
// Package for the file mode string parser: character codes, permission masks,
// parse phase and operator types, and the clause apply function.
// No dependencies; used by the interfaces and the top level.
package fmsp_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned ModeW = 12;

  // Who masks
  localparam logic [ModeW-1:0] M_USER  = 12'o5700;
  localparam logic [ModeW-1:0] M_GROUP = 12'o2070;
  localparam logic [ModeW-1:0] M_OTHER = 12'o0007;
  localparam logic [ModeW-1:0] M_ALL   = 12'o1777;

  // Permission bits
  localparam logic [ModeW-1:0] B_READ   = 12'o0444;
  localparam logic [ModeW-1:0] B_WRITE  = 12'o0222;
  localparam logic [ModeW-1:0] B_EXEC   = 12'o0111;
  localparam logic [ModeW-1:0] B_SETID  = 12'o6000;
  localparam logic [ModeW-1:0] B_STICKY = 12'o1000;

  // Character codes
  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_0     = 8'h30;
  localparam logic [CharW-1:0] CH_7     = 8'h37;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_EQ    = 8'h3D;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_U     = 8'h75;
  localparam logic [CharW-1:0] CH_G     = 8'h67;
  localparam logic [CharW-1:0] CH_O     = 8'h6F;
  localparam logic [CharW-1:0] CH_A     = 8'h61;
  localparam logic [CharW-1:0] CH_R     = 8'h72;
  localparam logic [CharW-1:0] CH_W     = 8'h77;
  localparam logic [CharW-1:0] CH_X     = 8'h78;
  localparam logic [CharW-1:0] CH_S     = 8'h73;
  localparam logic [CharW-1:0] CH_T     = 8'h74;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_DIGITS = 3'd1,
    PH_WHO    = 3'd2,
    PH_OPCHK  = 3'd3,
    PH_PFIRST = 3'd4,
    PH_PERM   = 3'd5,
    PH_SKIP   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_SET  = 2'd3
  } op_e;

  // Apply one operator to the mode, limited to the who mask
  function automatic logic [ModeW-1:0] apply_op(input logic [ModeW-1:0] mode,
                                                input logic [ModeW-1:0] operand,
                                                input logic [ModeW-1:0] who,
                                                input op_e op);
    logic [ModeW-1:0] b;
    logic [ModeW-1:0] r;
    b = operand & who;
    case (op)
      OP_ADD:  r = mode | b;
      OP_SUB:  r = mode & ~b;
      OP_SET:  r = (mode & ~who) | b;
      default: r = mode;
    endcase
    return r;
  endfunction

endpackage

// ===== design/fmsp_in_if.sv =====
// Input channel of the file mode string parser: one character per transaction.
// Depends on fmsp_pkg for the field widths.
interface fmsp_in_if;
  logic                          valid;
  logic                          ready;
  logic [fmsp_pkg::CharW-1:0]    ch;
  logic [fmsp_pkg::ModeW-1:0]    start_mode;

  modport source (output valid, output ch, output start_mode, input ready);
  modport sink   (input valid, input ch, input start_mode, output ready);
endinterface

// ===== design/fmsp_out_if.sv =====
// Output channel of the file mode string parser: one result per string.
// Depends on fmsp_pkg for the field widths.
interface fmsp_out_if;
  logic                          valid;
  logic                          ready;
  logic [fmsp_pkg::ModeW-1:0]    new_mode;
  logic                          invalid;

  modport source (output valid, output new_mode, output invalid, input ready);
  modport sink   (input valid, input new_mode, input invalid, output ready);
endinterface

// ===== design/file_mode_string_parser_top.sv =====
// Top level of the file mode string parser (chmod-style octal / symbolic modes).
// Depends on fmsp_pkg, fmsp_in_if and fmsp_out_if.
//
//   channel | direction | payload                  | transaction
//   in_i    | sink      | ch, start_mode           | one character, NUL ends string
//   out_o   | source    | new_mode, invalid        | one result per NUL character
//
// One character per cycle sustained while no stalled result holds a terminator.
// A character is held in the input register, and the parse state and the result
// register are updated from it when it leaves, so each result is registered.
// Reset clears the parse state to the start of a string; no clearing pass.
// A stalled result blocks only a terminator behind it; other characters flow on.
module file_mode_string_parser_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  fmsp_in_if.sink         in_i,
  fmsp_out_if.source      out_o
);

  localparam int unsigned CW = fmsp_pkg::CharW;
  localparam int unsigned MW = fmsp_pkg::ModeW;

  // Input register
  logic              stage_valid_q;
  logic [CW-1:0]     stage_ch_q;
  logic [MW-1:0]     stage_mode_q;

  // Parse state
  fmsp_pkg::phase_e  phase_q, phase_d;
  fmsp_pkg::op_e     op_q, op_d;
  logic [MW-1:0]     orig_q, orig_d;
  logic [MW-1:0]     work_q, work_d;
  logic [MW-1:0]     octal_q, octal_d;
  logic [MW-1:0]     who_q, who_d;
  logic [MW-1:0]     perm_q, perm_d;

  // Result register
  logic              out_valid_q;
  logic [MW-1:0]     out_mode_q;
  logic              out_bad_q;

  logic              emit;
  logic              bad;
  logic [MW-1:0]     res_mode;
  logic              out_free;
  logic              stage_adv;
  logic              in_fire;

  // Handshake
  assign out_free  = !out_valid_q || out_o.ready;
  assign stage_adv = stage_valid_q && ((stage_ch_q != fmsp_pkg::CH_NUL) || out_free);
  assign in_i.ready = !stage_valid_q || stage_adv;
  assign in_fire   = in_i.valid && in_i.ready;

  assign out_o.valid    = out_valid_q;
  assign out_o.new_mode = out_mode_q;
  assign out_o.invalid  = out_bad_q;

  // Per-character parse step
  always_comb begin
    logic [CW-1:0] c;
    logic [2:0]    trip;
    logic          do_who;
    logic          do_perm;
    logic          do_op;
    c        = stage_ch_q;
    trip     = '0;
    do_who   = 1'b0;
    do_perm  = 1'b0;
    do_op    = 1'b0;
    phase_d  = phase_q;
    op_d     = op_q;
    orig_d   = orig_q;
    work_d   = work_q;
    octal_d  = octal_q;
    who_d    = who_q;
    perm_d   = perm_q;
    emit     = 1'b0;
    bad      = 1'b0;
    res_mode = work_q;

    // first character samples the current mode
    if (phase_d == fmsp_pkg::PH_START) begin
      orig_d  = stage_mode_q;
      work_d  = stage_mode_q;
      octal_d = '0;
      phase_d = fmsp_pkg::PH_DIGITS;
    end

    case (phase_d)
      fmsp_pkg::PH_DIGITS: begin
        if (c >= fmsp_pkg::CH_0 && c <= fmsp_pkg::CH_7) begin
          octal_d = {octal_d[MW-4:0], c[2:0]};
        end else if (c == fmsp_pkg::CH_NUL) begin
          emit     = 1'b1;
          res_mode = octal_d;
        end else begin
          who_d   = '0;
          phase_d = fmsp_pkg::PH_WHO;
          do_who  = 1'b1;
        end
      end
      fmsp_pkg::PH_WHO:   do_who = 1'b1;
      fmsp_pkg::PH_OPCHK: do_op  = 1'b1;
      fmsp_pkg::PH_PFIRST: begin
        if (c == fmsp_pkg::CH_U || c == fmsp_pkg::CH_G || c == fmsp_pkg::CH_O) begin
          // copy source: one rwx triple repeated into all classes
          if (c == fmsp_pkg::CH_U)      trip = work_d[8:6];
          else if (c == fmsp_pkg::CH_G) trip = work_d[5:3];
          else                          trip = work_d[2:0];
          work_d  = fmsp_pkg::apply_op(work_d, {3'b000, trip, trip, trip}, who_d, op_d);
          phase_d = fmsp_pkg::PH_OPCHK;
        end else begin
          phase_d = fmsp_pkg::PH_PERM;
          do_perm = 1'b1;
        end
      end
      fmsp_pkg::PH_PERM: do_perm = 1'b1;
      default: begin
        // skipping the rest of a malformed string
        if (c == fmsp_pkg::CH_NUL) begin
          emit     = 1'b1;
          bad      = 1'b1;
          res_mode = orig_d;
        end else begin
          phase_d = fmsp_pkg::PH_SKIP;
        end
      end
    endcase

    // who letters; anything else closes the who list
    if (do_who) begin
      case (c)
        fmsp_pkg::CH_U: who_d = who_d | fmsp_pkg::M_USER;
        fmsp_pkg::CH_G: who_d = who_d | fmsp_pkg::M_GROUP;
        fmsp_pkg::CH_O: who_d = who_d | fmsp_pkg::M_OTHER;
        fmsp_pkg::CH_A: who_d = who_d | fmsp_pkg::M_ALL;
        default: begin
          if (who_d == '0) who_d = fmsp_pkg::M_ALL;
          phase_d = fmsp_pkg::PH_OPCHK;
          do_op   = 1'b1;
        end
      endcase
    end

    // permission letters; anything else applies the pending operator
    if (do_perm) begin
      case (c)
        fmsp_pkg::CH_R: perm_d = perm_d | fmsp_pkg::B_READ;
        fmsp_pkg::CH_W: perm_d = perm_d | fmsp_pkg::B_WRITE;
        fmsp_pkg::CH_X: perm_d = perm_d | fmsp_pkg::B_EXEC;
        fmsp_pkg::CH_S: perm_d = perm_d | fmsp_pkg::B_SETID;
        fmsp_pkg::CH_T: perm_d = perm_d | fmsp_pkg::B_STICKY;
        default: begin
          work_d  = fmsp_pkg::apply_op(work_d, perm_d, who_d, op_d);
          phase_d = fmsp_pkg::PH_OPCHK;
          do_op   = 1'b1;
        end
      endcase
    end

    // operator, clause separator or terminator
    if (do_op) begin
      case (c)
        fmsp_pkg::CH_PLUS, fmsp_pkg::CH_MINUS, fmsp_pkg::CH_EQ: begin
          if (c == fmsp_pkg::CH_PLUS)       op_d = fmsp_pkg::OP_ADD;
          else if (c == fmsp_pkg::CH_MINUS) op_d = fmsp_pkg::OP_SUB;
          else                              op_d = fmsp_pkg::OP_SET;
          perm_d  = '0;
          phase_d = fmsp_pkg::PH_PFIRST;
        end
        fmsp_pkg::CH_COMMA: begin
          who_d   = '0;
          phase_d = fmsp_pkg::PH_WHO;
        end
        fmsp_pkg::CH_NUL: begin
          emit     = 1'b1;
          res_mode = work_d;
        end
        default: phase_d = fmsp_pkg::PH_SKIP;
      endcase
    end

    // a result ends the string
    if (emit) begin
      phase_d = fmsp_pkg::PH_START;
      octal_d = '0;
      who_d   = '0;
      op_d    = fmsp_pkg::OP_NONE;
      perm_d  = '0;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stage_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_ch_q   <= in_i.ch;
      stage_mode_q <= in_i.start_mode;
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fmsp_pkg::PH_START;
      op_q    <= fmsp_pkg::OP_NONE;
      orig_q  <= '0;
      work_q  <= '0;
      octal_q <= '0;
      who_q   <= '0;
      perm_q  <= '0;
    end else if (stage_adv) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      orig_q  <= orig_d;
      work_q  <= work_d;
      octal_q <= octal_d;
      who_q   <= who_d;
      perm_q  <= perm_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv && emit) begin
      out_mode_q <= res_mode;
      out_bad_q  <= bad;
    end
  end

  // Assertions
  a_term_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_adv && (stage_ch_q == fmsp_pkg::CH_NUL) |=> out_valid_q)
    else $error("terminator did not produce a result");

  a_result_from_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(stage_valid_q && (stage_ch_q == fmsp_pkg::CH_NUL)))
    else $error("result without a terminator");

  a_term_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_adv && (stage_ch_q == fmsp_pkg::CH_NUL) |=> phase_q == fmsp_pkg::PH_START)
    else $error("parser did not return to string start after terminator");

  a_skip_is_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_adv && (stage_ch_q == fmsp_pkg::CH_NUL) && (phase_q == fmsp_pkg::PH_SKIP)
    |=> out_bad_q)
    else $error("malformed string reported as valid");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(out_mode_q) && $stable(out_bad_q))
    else $error("stalled result overwritten");

endmodule
